/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on each rising clock edge, masked while reset is low.
`define MF3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on each rising clock edge, also active while reset is low.
`define MF3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mf3_pkg.sv */
package mf3_pkg;

    // Build-time defaults
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 12;
    localparam int ROW_W      = IMG_H_BITS + 1;   // row count runs to height+1 while draining
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;

    // Result queue
    localparam int FIFO_DEPTH = 8;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

    // Request opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // One window column, top to bottom
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    // Window: [0] left, [1] center, [2] right
    typedef col_t [2:0] win_t;

    // Control that travels with a window through the median pipe
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

/* rtl/median_filter_3x3.sv */
// 3x3 median filter over a raster-order stream of 8-bit pixels.
// Input channel (in_valid/in_ready): op = OP_PIXEL carries pixel_in, op = OP_DRAIN
// flushes one pending result once the whole frame is in. Early drains and pixels
// that arrive while the frame is full are taken and ignored.
// Output channel (out_valid/out_ready): pixel_out is the median of the edge-clamped
// neighborhood, frame_last marks the last pixel of the frame. Results trail the
// input by image_width+1 requests, image_width in a one-row frame; that many
// final results come from drains. Throughput: one request per clock while the
// result queue has room. A frame of one row costs one extra cycle with in_ready
// low after its last pixel, for an internal column push. Each result passes the
// line-store read, four-stage median pipe and result queue before it is offered.
// Line history sits in one 2-pixel-wide RAM of MAX_WIDTH entries, read-modify-
// written per pixel, with a bypass for back-to-back hits on one column.
// A stalled receiver fills an 8-entry result queue; in_ready drops when every
// queue slot is claimed by results in flight or waiting, and for the column push.
// Reset clears the frame position and queue, sets 640x480, and needs no
// clearing pass. Any register write restarts the frame.
module median_filter_3x3 #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mf3_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  mf3_pkg::pix_t                  pixel_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mf3_pkg::pix_t                  pixel_out,
    output logic                           frame_last
);

    import mf3_pkg::*;

    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int RESET_W_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int FAW         = $clog2(FIFO_DEPTH);
    localparam int RAM_W       = 2 * PIX_W;

    typedef enum logic [1:0] {
        WIN_MID,     // interior column
        WIN_LEFT,    // first column, left edge replicated
        WIN_RIGHT,   // last column, right edge replicated
        WIN_NARROW   // one-column image
    } wmode_t;

    // ---------------- configuration ----------------
    logic [WW-1:0]         w_reg, w_next;
    logic [IMG_H_BITS-1:0] h_reg, h_next;
    logic                  cfg_hit;
    logic [IMG_W_BITS-1:0] cfg_w_raw;
    logic [IMG_H_BITS-1:0] cfg_h_raw;

    assign cfg_w_raw = cfg_data[IMG_W_BITS-1:0];
    assign cfg_h_raw = cfg_data[IMG_H_BITS-1:0];

    // Width clamps to 1..MAX_WIDTH, height zero acts as one
    always_comb
    begin
        w_next  = w_reg;
        h_next  = h_reg;
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_w_raw == '0)
                        w_next = WW'(1);
                    else if (32'(cfg_w_raw) > 32'(MAX_WIDTH))
                        w_next = WW'(MAX_WIDTH);
                    else
                        w_next = WW'(cfg_w_raw);
                end
                REG_IMAGE_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    h_next  = (cfg_h_raw == '0) ? IMG_H_BITS'(1) : cfg_h_raw;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ---------------- issue ----------------
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             pad_reg, pad_next;
    logic [FAW:0]     occ_reg, occ_next;

    logic [ROW_W-1:0] h_ext, h_plus1;
    logic             col_at_end, full, lag_met, is_pixel, take;
    logic             pix_step, drain_step, step, emit_issue, last_issue;
    logic             pop;
    wmode_t           mode_issue;

    assign h_ext      = ROW_W'(h_reg);
    assign h_plus1    = h_ext + ROW_W'(1);
    assign col_at_end = (WW'(col_reg) == w_reg - WW'(1));
    assign full       = (row_reg >= h_ext);
    assign lag_met    = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign is_pixel   = (op == OP_PIXEL);

    assign in_ready   = !pad_reg && (occ_reg < (FAW+1)'(FIFO_DEPTH));
    assign take       = in_valid && in_ready;
    assign pix_step   = take && is_pixel && !full;
    assign drain_step = take && !is_pixel && full;
    assign step       = pix_step || drain_step || pad_reg;
    assign emit_issue = (pix_step && lag_met) || drain_step;
    assign last_issue = drain_step && (row_reg == h_plus1);
    assign pop        = out_valid && out_ready;

    // A one-row frame needs one extra column push before draining
    assign pad_next = !cfg_hit && pix_step && col_at_end && (h_reg == IMG_H_BITS'(1));

    // Window shape follows the column of the newest position
    always_comb
    begin
        if (w_reg == WW'(1))
            mode_issue = WIN_NARROW;
        else if (col_reg == '0)
            mode_issue = WIN_RIGHT;
        else if (col_reg == CW'(1))
            mode_issue = WIN_LEFT;
        else
            mode_issue = WIN_MID;
    end

    // Position walks past the frame end while draining
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (step)
        begin
            if (last_issue)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_at_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Results claimed but not yet taken
    always_comb
    begin
        occ_next = occ_reg;
        if (emit_issue && !pop)
            occ_next = occ_reg + (FAW+1)'(1);
        else if (!emit_issue && pop)
            occ_next = occ_reg - (FAW+1)'(1);
    end

    // ---------------- line store ----------------
    logic             s1_valid_reg, s1_wr_reg, s1_emit_reg;
    logic             s1_last_reg, s1_topc_reg, s1_botc_reg;
    pix_t             s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    wmode_t           s1_mode_reg;
    logic             fwd_hit_reg;
    logic [RAM_W-1:0] fwd_data_reg;
    logic [RAM_W-1:0] ram_rd, line_pair, wr_pair;
    logic             ram_we;
    pix_t             near_pix, far_pix;

    mf3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair),
        .rd_en   (step),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    // Pair: upper byte = row above, lower byte = two rows above
    assign line_pair = fwd_hit_reg ? fwd_data_reg : ram_rd;
    assign near_pix  = line_pair[RAM_W-1:PIX_W];
    assign far_pix   = line_pair[PIX_W-1:0];
    assign ram_we    = s1_valid_reg && s1_wr_reg;
    assign wr_pair   = {s1_pix_reg, near_pix};

    // ---------------- column vector and window ----------------
    col_t vec, prev1_reg, prev2_reg;
    win_t win;
    tag_t med_in_tag, med_out_tag;
    pix_t med_out_pix;

    // Top and bottom replicate the center row at the frame edges
    always_comb
    begin
        vec.mid = near_pix;
        vec.top = s1_topc_reg ? near_pix : far_pix;
        vec.bot = s1_botc_reg ? near_pix : s1_pix_reg;
    end

    always_comb
    begin
        case (s1_mode_reg)
            WIN_MID:
            begin
                win[0] = prev2_reg;
                win[1] = prev1_reg;
                win[2] = vec;
            end
            WIN_LEFT:
            begin
                win[0] = prev1_reg;
                win[1] = prev1_reg;
                win[2] = vec;
            end
            WIN_RIGHT:
            begin
                win[0] = prev2_reg;
                win[1] = prev1_reg;
                win[2] = prev1_reg;
            end
            default:
            begin
                win[0] = prev1_reg;
                win[1] = prev1_reg;
                win[2] = prev1_reg;
            end
        endcase
    end

    assign med_in_tag.valid = s1_valid_reg && s1_emit_reg;
    assign med_in_tag.last  = s1_last_reg;

    mf3_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (med_in_tag),
        .in_win    (win),
        .out_tag   (med_out_tag),
        .out_pixel (med_out_pix)
    );

    // ---------------- result queue ----------------
    pix_t           fifo_pix_reg  [FIFO_DEPTH];
    logic           fifo_last_reg [FIFO_DEPTH];
    logic [FAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FAW:0]   fcnt_reg;

    assign out_valid  = (fcnt_reg != '0);
    assign pixel_out  = fifo_pix_reg[rd_ptr_reg];
    assign frame_last = fifo_last_reg[rd_ptr_reg];

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= WW'(RESET_W_EFF);
            h_reg        <= IMG_H_BITS'(RESET_HEIGHT);
            col_reg      <= '0;
            row_reg      <= '0;
            pad_reg      <= 1'b0;
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
            s1_emit_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fcnt_reg     <= '0;
        end
        else
        begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pad_reg      <= pad_next;
            occ_reg      <= occ_next;
            s1_valid_reg <= step;
            s1_wr_reg    <= pix_step;
            s1_emit_reg  <= emit_issue;
            // Read issued in the same cycle as a write to that column sees old data
            fwd_hit_reg  <= step && ram_we && (col_reg == s1_col_reg);
            if (med_out_tag.valid)
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
            if (med_out_tag.valid && !pop)
                fcnt_reg <= fcnt_reg + (FAW+1)'(1);
            else if (!med_out_tag.valid && pop)
                fcnt_reg <= fcnt_reg - (FAW+1)'(1);
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        s1_last_reg  <= last_issue;
        s1_pix_reg   <= pixel_in;
        s1_col_reg   <= col_reg;
        s1_mode_reg  <= mode_issue;
        s1_topc_reg  <= (row_reg == ROW_W'(1));
        s1_botc_reg  <= full;
        fwd_data_reg <= wr_pair;
        if (s1_valid_reg)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= vec;
        end
        if (med_out_tag.valid)
        begin
            fifo_pix_reg[wr_ptr_reg]  <= med_out_pix;
            fifo_last_reg[wr_ptr_reg] <= med_out_tag.last;
        end
    end

endmodule

/* rtl/mf3_ram.sv */
module mf3_ram #(
    parameter int WIDTH = 2 * mf3_pkg::PIX_W,
    parameter int DEPTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/mf3_median.sv */
module mf3_median (
    input  logic          clk,
    input  logic          rst_n,
    input  mf3_pkg::tag_t in_tag,
    input  mf3_pkg::win_t in_win,
    output mf3_pkg::tag_t out_tag,
    output mf3_pkg::pix_t out_pixel
);

    import mf3_pkg::*;

    function automatic pix_t min2(pix_t a, pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(pix_t a, pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sort one column: top = smallest, bot = largest
    function automatic col_t sort3(col_t c);
        pix_t lo1;
        pix_t hi1;
        pix_t lo2;
        col_t s;
        lo1   = min2(c.top, c.mid);
        hi1   = max2(c.top, c.mid);
        lo2   = min2(hi1, c.bot);
        s.bot = max2(hi1, c.bot);
        s.top = min2(lo1, lo2);
        s.mid = max2(lo1, lo2);
        return s;
    endfunction

    tag_t t1_reg, t2_reg, t3_reg, t4_reg;
    win_t win_reg;
    win_t srt_reg;
    pix_t lo_reg, md_reg, hi_reg;
    pix_t res_reg;

    // Tags: valid bits need reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else
        begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
        end
    end

    // Window -> column sort -> three candidates -> median
    always_ff @(posedge clk)
    begin
        win_reg <= in_win;
        for (int i = 0; i < 3; i++)
        begin
            srt_reg[i] <= sort3(win_reg[i]);
        end
        lo_reg  <= max2(max2(srt_reg[0].top, srt_reg[1].top), srt_reg[2].top);
        md_reg  <= med3(srt_reg[0].mid, srt_reg[1].mid, srt_reg[2].mid);
        hi_reg  <= min2(min2(srt_reg[0].bot, srt_reg[1].bot), srt_reg[2].bot);
        res_reg <= med3(lo_reg, md_reg, hi_reg);
    end

    assign out_tag   = t4_reg;
    assign out_pixel = res_reg;

endmodule

/* rtl/mf3_checker.sv */
`include "assert_macros.svh"

module mf3_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          op,
    input logic          out_valid,
    input logic          out_ready,
    input mf3_pkg::pix_t pixel_out,
    input logic          frame_last
);

    import mf3_pkg::*;

    // Edges from request acceptance to a result showing on an empty output
    localparam int OUT_LAG = 6;

    // A waiting result holds until taken
    `MF3_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_last), "result changed while stalled")

    // Reset empties the result queue
    `MF3_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result offered after reset")

    // A result on an idle output follows an accepted request by the pipe depth
    `MF3_ASSERT(a_out_lag, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, OUT_LAG), "result without a matching request")

    // The frame's last result is always flushed by a drain request
    `MF3_ASSERT(a_last_drain, clk, rst_n, $rose(out_valid) && frame_last |-> $past(op == OP_DRAIN, OUT_LAG), "frame end not from a drain")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);
